// File: rtl/core/rrud_pkg.sv
// shared types and constants of the radial ripple uv displacement block
// holds the controller command and status structs, table entry layout and sizes
`timescale 1ns / 1ps

package rrud_pkg;

  localparam int MaxSourcesDef = 8;
  localparam int ExpDepthDef   = 256;

  localparam int DataW    = 24;
  localparam int ModeW    = 2;
  localparam int AddrMaxW = 6;
  localparam int SqSteps  = 25;
  localparam int DivNumW  = 50;
  localparam int DivDenW  = 25;
  localparam int MulAW    = 33;
  localparam int MulBW    = 25;
  localparam int ProdW    = MulAW + MulBW;
  localparam int ExpW     = 31;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_VERTEX = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INS,
    OP_RD,
    OP_TICK_EV,
    OP_DX,
    OP_D2X,
    OP_D2Y,
    OP_R2,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_DIV_S,
    OP_X,
    OP_T,
    OP_IDX,
    OP_G,
    OP_H1,
    OP_DIV_R,
    OP_H,
    OP_DIV_UX,
    OP_UX_L,
    OP_UX_H,
    OP_DIV_UY,
    OP_UY_L,
    OP_UY_H,
    OP_RES
  } op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_CUR,
    RES_NEW
  } res_e;

  typedef struct packed {
    op_e                 op;
    logic                load;
    res_e                res;
    logic [AddrMaxW-1:0] raddr;
    logic [AddrMaxW-1:0] waddr;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic not_cov;
    logic div_done;
    logic d_zero;
  } status_t;

  typedef struct packed {
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] rad;
    logic [DataW-1:0] peak;
    logic [DataW-1:0] age;
  } src_entry_t;

endpackage

// File: rtl/core/rrud_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on rrud_pkg for operand widths
`timescale 1ns / 1ps

module rrud_div import rrud_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  localparam int CntW = $clog2(DivNumW + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  assign trial = {rem_q, num_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], 1'b0};
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/rrud_dp.sv
// datapath: source table, shared multiplier, square root, exp table, divider
// depends on rrud_pkg and rrud_div; driven by commands from rrud_ctrl
`timescale 1ns / 1ps

module rrud_dp import rrud_pkg::*; #(
  parameter int MaxSources = MaxSourcesDef,
  parameter int ExpDepth   = ExpDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic [DataW-1:0] pos_x_i,
  input  logic [DataW-1:0] pos_y_i,
  input  logic [DataW-1:0] orig_u_i,
  input  logic [DataW-1:0] orig_v_i,
  input  logic [DataW-1:0] cur_u_i,
  input  logic [DataW-1:0] cur_v_i,
  input  logic [DataW-1:0] src_radius_i,
  input  logic [DataW-1:0] src_peak_i,
  input  logic [DataW-1:0] elapsed_i,
  output logic [DataW-1:0] new_u_o,
  output logic [DataW-1:0] new_v_o,
  output logic             covered_o,
  output logic             table_full_o
);

  localparam int AW      = (MaxSources > 1) ? $clog2(MaxSources) : 1;
  localparam int IdxW    = $clog2(ExpDepth);
  localparam int IdxProdW = 36 + IdxW + 1;
  localparam logic [63:0] ExpStep = (64'd16 << 30) / ExpDepth;
  localparam logic [38:0] HLimit  = 39'd1 << 38;
  localparam logic [27:0] FarLimit = 28'd4 << 16;
  // ceil(2^36 / 25), exact quotient for any 31-bit numerator
  localparam logic [31:0] Recip25 = 32'd2748779070;

  typedef logic [ExpW-1:0] exp_tab_t [ExpDepth];

  // exp(-16/depth) by taylor series, then the table by repeated rounded products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t           tab;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    logic [63:0]        prod;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * ExpStep) >> 30) / 64'(n);
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    r = (sum > 0) ? 64'(sum) : 64'd0;
    tab[0] = ExpW'(64'd1 << 30);
    for (int i = 1; i < ExpDepth; i++) begin
      prod   = 64'(tab[i-1]) * r + (64'd1 << 29);
      tab[i] = prod[60:30];
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

  // latched transaction payload
  logic [DataW-1:0] px_q, py_q, ou_q, ov_q, cu_q, cv_q, rad_in_q, peak_in_q, el_q;

  src_entry_t mem_q [MaxSources];
  src_entry_t rd_q;
  src_entry_t wdata;
  logic       we;
  logic       live;
  logic [DataW:0] age_sum;

  logic [DataW:0]     dx_q, dy_q, adx, ady;
  logic [DivNumW-1:0] dist2_q;
  logic [DivNumW-1:0] sq_v_q, sq_res_q, sq_bit_q, sq_trial;
  logic [DivDenW-1:0] d_val;
  logic [DataW-1:0]   pmag;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;

  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_done;
  logic [DivNumW-1:0] quo;

  logic [30:0]         s_num;
  logic [62:0]         s_prod;
  logic [26:0]         s_q;
  logic [27:0]         x_w, ax_w;
  logic [17:0]         ax_q;
  logic                far_q;
  logic [35:0]         t_q;
  logic [IdxProdW-1:0] idx_prod;
  logic [IdxW-1:0]     idx_q;
  logic [ExpW-1:0]     g_q;
  logic [DataW-1:0]    h1_q;
  logic [MulAW-1:0]    factor;
  logic [41:0]         hp;
  logic [38:0]         h_mag_q;
  logic [44:0]         acc_q;
  logic [63:0]         p_tot;
  logic [40:0]         disp_mag;
  logic [40:0]         dux_q, duy_q;
  logic signed [41:0]  sum_u, sum_v;

  logic [DataW-1:0] new_u_q, new_v_q;
  logic             covered_q, full_q;

  function automatic logic [DataW-1:0] sat24(logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'h7fffff;
    else if (v < -42'sd8388608) return 24'h800000;
    else return v[DataW-1:0];
  endfunction

  assign adx   = dx_q[DataW] ? -dx_q : dx_q;
  assign ady   = dy_q[DataW] ? -dy_q : dy_q;
  assign d_val = sq_res_q[DivDenW-1:0];
  assign pmag  = rd_q.peak[DataW-1] ? -rd_q.peak : rd_q.peak;
  assign live  = rd_q.age <= rd_q.rad;
  assign age_sum = {1'b0, rd_q.age} + {1'b0, el_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_D2X: begin
        mul_a = MulAW'(adx);
        mul_b = MulBW'(adx);
      end
      OP_D2Y: begin
        mul_a = MulAW'(ady);
        mul_b = MulBW'(ady);
      end
      OP_R2: begin
        mul_a = MulAW'(rd_q.rad);
        mul_b = MulBW'(rd_q.rad);
      end
      OP_T: begin
        mul_a = MulAW'(ax_q);
        mul_b = MulBW'(ax_q);
      end
      OP_H1: begin
        mul_a = MulAW'(g_q);
        mul_b = MulBW'(pmag);
      end
      OP_H: begin
        mul_a = factor;
        mul_b = MulBW'(h1_q);
      end
      OP_UX_L, OP_UY_L: begin
        mul_a = MulAW'(quo[MulBW-1:0]);
        mul_b = MulBW'(h_mag_q[19:0]);
      end
      OP_UX_H, OP_UY_H: begin
        mul_a = MulAW'(quo[MulBW-1:0]);
        mul_b = MulBW'(h_mag_q[38:20]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = ProdW'(mul_a) * ProdW'(mul_b);
  assign factor = quo[MulAW-1:0] + MulAW'(65536);
  assign hp     = prod[57:16];
  assign p_tot  = 64'(acc_q) + (64'(prod) << 20);
  assign disp_mag = {1'b0, p_tot[63:24]};

  // scaled distance (64*d + 12) / 25 by reciprocal multiply
  assign s_num  = {d_val, 6'b0} + 31'd12;
  assign s_prod = 63'(s_num) * 63'(Recip25);

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DivDenW'(1);
    case (cmd_i.op)
      OP_DIV_R: begin
        div_start = 1'b1;
        div_num   = DivNumW'({rd_q.age, 8'b0});
        div_den   = (rd_q.rad == '0) ? DivDenW'(1) : DivDenW'(rd_q.rad);
      end
      OP_DIV_UX: begin
        div_start = 1'b1;
        div_num   = DivNumW'({adx, 24'b0});
        div_den   = d_val;
      end
      OP_DIV_UY: begin
        div_start = 1'b1;
        div_num   = DivNumW'({ady, 24'b0});
        div_den   = d_val;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rrud_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign x_w      = {1'b0, s_q} - {4'b0, rd_q.age};
  assign ax_w     = x_w[27] ? -x_w : x_w;
  assign idx_prod = IdxProdW'(t_q) * IdxProdW'(ExpDepth);
  assign sq_trial = sq_res_q + sq_bit_q;

  // source table write port
  always_comb begin
    we    = 1'b0;
    wdata = rd_q;
    if (cmd_i.op == OP_INS) begin
      we    = 1'b1;
      wdata = '{x: px_q, y: py_q, rad: rad_in_q, peak: peak_in_q, age: '0};
    end else if (cmd_i.op == OP_TICK_EV && live) begin
      we        = 1'b1;
      wdata.age = age_sum[DataW] ? '1 : age_sum[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[cmd_i.waddr[AW-1:0]] <= wdata;
    if (cmd_i.op == OP_RD) rd_q <= mem_q[cmd_i.raddr[AW-1:0]];
  end

  assign sum_u = {{18{ou_q[DataW-1]}}, ou_q} + {dux_q[40], dux_q};
  assign sum_v = {{18{ov_q[DataW-1]}}, ov_q} + {duy_q[40], duy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      ou_q      <= orig_u_i;
      ov_q      <= orig_v_i;
      cu_q      <= cur_u_i;
      cv_q      <= cur_v_i;
      rad_in_q  <= src_radius_i;
      peak_in_q <= src_peak_i;
      el_q      <= elapsed_i;
    end
    case (cmd_i.op)
      OP_DX: begin
        dx_q <= {px_q[DataW-1], px_q} - {rd_q.x[DataW-1], rd_q.x};
        dy_q <= {py_q[DataW-1], py_q} - {rd_q.y[DataW-1], rd_q.y};
      end
      OP_D2X: dist2_q <= prod[DivNumW-1:0];
      OP_D2Y: dist2_q <= dist2_q + prod[DivNumW-1:0];
      OP_SQ_INIT: begin
        sq_v_q   <= dist2_q;
        sq_res_q <= '0;
        sq_bit_q <= DivNumW'(1) << 48;
        dux_q    <= '0;
        duy_q    <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q   <= sq_v_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_DIV_S: s_q <= s_prod[62:36];
      OP_X: begin
        ax_q  <= ax_w[17:0];
        far_q <= ax_w >= FarLimit;
      end
      OP_T:   t_q   <= prod[35:0];
      OP_IDX: idx_q <= idx_prod[36 +: IdxW];
      OP_G:   g_q   <= far_q ? '0 : ExpTab[idx_q];
      OP_H1:  h1_q  <= prod[53:30];
      OP_H:   h_mag_q <= (hp > 42'(HLimit)) ? HLimit : hp[38:0];
      OP_UX_L, OP_UY_L: acc_q <= prod[44:0];
      OP_UX_H: dux_q <= (rd_q.peak[DataW-1] ^ dx_q[DataW]) ? -disp_mag : disp_mag;
      OP_UY_H: duy_q <= (rd_q.peak[DataW-1] ^ dy_q[DataW]) ? -disp_mag : disp_mag;
      OP_RES: begin
        case (cmd_i.res)
          RES_FULL: begin
            new_u_q   <= '0;
            new_v_q   <= '0;
            covered_q <= 1'b0;
            full_q    <= 1'b1;
          end
          RES_CUR: begin
            new_u_q   <= cu_q;
            new_v_q   <= cv_q;
            covered_q <= 1'b0;
            full_q    <= 1'b0;
          end
          RES_NEW: begin
            new_u_q   <= sat24(sum_u);
            new_v_q   <= sat24(sum_v);
            covered_q <= 1'b1;
            full_q    <= 1'b0;
          end
          default: begin
            new_u_q   <= '0;
            new_v_q   <= '0;
            covered_q <= 1'b0;
            full_q    <= 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign status_o.live     = live;
  assign status_o.not_cov  = dist2_q > prod[DivNumW-1:0];
  assign status_o.div_done = div_done;
  assign status_o.d_zero   = d_val == '0;

  assign new_u_o      = new_u_q;
  assign new_v_o      = new_v_q;
  assign covered_o    = covered_q;
  assign table_full_o = full_q;

endmodule

// File: rtl/core/rrud_ctrl.sv
// controller: sequences insert, tick compaction and vertex evaluation
// depends on rrud_pkg; issues commands to rrud_dp and reads its status
`timescale 1ns / 1ps

module rrud_ctrl import rrud_pkg::*; #(
  parameter int MaxSources = MaxSourcesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cmd_t             cmd_o,
  input  status_t          status_i
);

  localparam int CW = $clog2(MaxSources + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INS, ST_T_RD, ST_T_EV, ST_V_RD, ST_V_DX, ST_V_D2X, ST_V_D2Y, ST_V_R2,
    ST_SQ_INIT, ST_SQ_STEP, ST_DIV_S, ST_X, ST_T, ST_IDX, ST_G, ST_H1,
    ST_DIV_R, ST_WAIT_R, ST_H, ST_DIV_UX, ST_WAIT_UX, ST_UX_L, ST_UX_H,
    ST_DIV_UY, ST_WAIT_UY, ST_UY_L, ST_UY_H, ST_FIN
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  idx_q;
  logic [CW-1:0]  k_q;
  logic [CW-1:0]  k_next;
  logic [4:0]     sq_cnt_q;
  res_e           res_q;
  logic           out_valid_q;
  logic           commit;
  logic           full;

  assign commit = !out_valid_q || out_ready_i;
  assign full   = count_q >= CW'(MaxSources);
  assign k_next = k_q + CW'(status_i.live);

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.res   = res_q;
    cmd_o.raddr = AddrMaxW'(idx_q);
    cmd_o.waddr = AddrMaxW'(k_q);
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_INS: begin
        cmd_o.op    = full ? OP_NONE : OP_INS;
        cmd_o.waddr = AddrMaxW'(count_q);
      end
      ST_T_RD, ST_V_RD: cmd_o.op = OP_RD;
      ST_T_EV:    cmd_o.op = OP_TICK_EV;
      ST_V_DX:    cmd_o.op = OP_DX;
      ST_V_D2X:   cmd_o.op = OP_D2X;
      ST_V_D2Y:   cmd_o.op = OP_D2Y;
      ST_V_R2:    cmd_o.op = OP_R2;
      ST_SQ_INIT: cmd_o.op = OP_SQ_INIT;
      ST_SQ_STEP: cmd_o.op = OP_SQ_STEP;
      ST_DIV_S:   cmd_o.op = OP_DIV_S;
      ST_X:       cmd_o.op = OP_X;
      ST_T:       cmd_o.op = OP_T;
      ST_IDX:     cmd_o.op = OP_IDX;
      ST_G:       cmd_o.op = OP_G;
      ST_H1:      cmd_o.op = OP_H1;
      ST_DIV_R:   cmd_o.op = OP_DIV_R;
      ST_H:       cmd_o.op = OP_H;
      ST_DIV_UX:  cmd_o.op = OP_DIV_UX;
      ST_UX_L:    cmd_o.op = OP_UX_L;
      ST_UX_H:    cmd_o.op = OP_UX_H;
      ST_DIV_UY:  cmd_o.op = OP_DIV_UY;
      ST_UY_L:    cmd_o.op = OP_UY_L;
      ST_UY_H:    cmd_o.op = OP_UY_H;
      ST_FIN:     cmd_o.op = commit ? OP_RES : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      sq_cnt_q    <= '0;
      res_q       <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_FIN the handoff below decides the valid flag
      if (out_valid_q && out_ready_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            case (mode_i)
              MODE_INSERT: state_q <= ST_INS;
              MODE_TICK: begin
                idx_q <= '0;
                k_q   <= '0;
                res_q <= RES_ZERO;
                state_q <= (count_q == '0) ? ST_FIN : ST_T_RD;
              end
              MODE_VERTEX: begin
                res_q <= RES_CUR;
                idx_q <= count_q - 1'b1;
                state_q <= (count_q == '0) ? ST_FIN : ST_V_RD;
              end
              default: begin
                res_q   <= RES_ZERO;
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_INS: begin
          if (full) begin
            res_q <= RES_FULL;
          end else begin
            res_q   <= RES_ZERO;
            count_q <= count_q + 1'b1;
          end
          state_q <= ST_FIN;
        end
        ST_T_RD: state_q <= ST_T_EV;
        ST_T_EV: begin
          k_q <= k_next;
          if (idx_q + 1'b1 == count_q) begin
            count_q <= k_next;
            state_q <= ST_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_T_RD;
          end
        end
        ST_V_RD:  state_q <= ST_V_DX;
        ST_V_DX:  state_q <= ST_V_D2X;
        ST_V_D2X: state_q <= ST_V_D2Y;
        ST_V_D2Y: state_q <= ST_V_R2;
        ST_V_R2: begin
          if (!status_i.not_cov) begin
            state_q <= ST_SQ_INIT;
          end else if (idx_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= ST_V_RD;
          end
        end
        ST_SQ_INIT: begin
          sq_cnt_q <= '0;
          res_q    <= RES_NEW;
          state_q  <= ST_SQ_STEP;
        end
        ST_SQ_STEP: begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
          if (sq_cnt_q == 5'(SqSteps - 1)) state_q <= ST_DIV_S;
        end
        ST_DIV_S:  state_q <= ST_X;
        ST_X:      state_q <= ST_T;
        ST_T:      state_q <= ST_IDX;
        ST_IDX:    state_q <= ST_G;
        ST_G:      state_q <= ST_H1;
        ST_H1:     state_q <= ST_DIV_R;
        ST_DIV_R:  state_q <= ST_WAIT_R;
        ST_WAIT_R: if (status_i.div_done) state_q <= ST_H;
        ST_H:      state_q <= status_i.d_zero ? ST_FIN : ST_DIV_UX;
        ST_DIV_UX: state_q <= ST_WAIT_UX;
        ST_WAIT_UX: if (status_i.div_done) state_q <= ST_UX_L;
        ST_UX_L:   state_q <= ST_UX_H;
        ST_UX_H:   state_q <= ST_DIV_UY;
        ST_DIV_UY: state_q <= ST_WAIT_UY;
        ST_WAIT_UY: if (status_i.div_done) state_q <= ST_UY_L;
        ST_UY_L:   state_q <= ST_UY_H;
        ST_UY_H:   state_q <= ST_FIN;
        ST_FIN: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/radial_ripple_uv_displace.sv
// top level of the radial ripple uv displacement block
// depends on rrud_pkg, rrud_ctrl, rrud_dp (which holds rrud_div)
`timescale 1ns / 1ps

// Keeps a table of up to MAX_SOURCES ripple sources and takes one transaction
// at a time on the slave stream; tuser selects insert, tick or vertex. Every
// transaction gives one result on the master stream, held in an output register
// so the next transaction may start while it waits. A tick reads each stored
// source in turn and compacts the live ones. A vertex walks the single-port
// source table from the newest until one source covers it; the covering source
// then runs a 25-step square root and three passes through the shared
// bit-serial divider (one pass at zero distance). A result held by the master
// side stalls the next one in ST_FIN.
module radial_ripple_uv_displace import rrud_pkg::*; #(
  parameter int MAX_SOURCES     = MaxSourcesDef,
  parameter int EXP_TABLE_DEPTH = ExpDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, orig_u, orig_v, cur_u, cur_v, src_radius, src_peak, elapsed
  input  logic [215:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_u, new_v
  output logic [47:0]  m_axis_tdata,
  // covered, table_full
  output logic [1:0]   m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  rrud_ctrl #(
    .MaxSources(MAX_SOURCES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rrud_dp #(
    .MaxSources(MAX_SOURCES),
    .ExpDepth  (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pos_x_i     (s_axis_tdata[23:0]),
    .pos_y_i     (s_axis_tdata[47:24]),
    .orig_u_i    (s_axis_tdata[71:48]),
    .orig_v_i    (s_axis_tdata[95:72]),
    .cur_u_i     (s_axis_tdata[119:96]),
    .cur_v_i     (s_axis_tdata[143:120]),
    .src_radius_i(s_axis_tdata[167:144]),
    .src_peak_i  (s_axis_tdata[191:168]),
    .elapsed_i   (s_axis_tdata[215:192]),
    .new_u_o     (m_axis_tdata[23:0]),
    .new_v_o     (m_axis_tdata[47:24]),
    .covered_o   (m_axis_tuser[0]),
    .table_full_o(m_axis_tuser[1])
  );

`ifndef NO_ASSERTIONS
  // one transaction in flight: the slave side closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("slave side still open after accept");

  // a dropped insert carries no coordinates and no coverage
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
    else $error("table_full result with nonzero payload");

  // compaction never writes ahead of the entry being read
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_TICK_EV) |-> (cmd.waddr <= cmd.raddr))
    else $error("tick compaction write beyond read index");
`endif

endmodule
